// ===== design/irad_pkg.sv =====
// Shared types, constants and a helper function of the integer to radix digits unit.
`timescale 1ns / 1ps

package irad_pkg;

    // Register encoding of radix_select; the unused code falls back to decimal.
    localparam logic [1:0] RADIX_SEL_OCT = 2'd1;
    localparam logic [1:0] RADIX_SEL_HEX = 2'd2;

    localparam logic [6:0] ASCII_ZERO       = 7'h30;
    localparam logic [6:0] ASCII_A_MINUS_10 = 7'h37;
    localparam logic [3:0] DIGIT_TEN        = 4'd10;
    localparam logic [3:0] BCD_ADJ_LIMIT    = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD      = 4'd3;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } t_radix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    // Control half of a queued job from the front part to the back part.
    typedef struct packed {
        logic   valid;
        t_radix radix;
    } t_job_ctl;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
        logic [6:0] d_ext;
        d_ext = {3'b000, d};
        if (d < DIGIT_TEN) begin
            return ASCII_ZERO + d_ext;
        end
        return ASCII_A_MINUS_10 + d_ext;
    endfunction

endpackage

// ===== design/integer_to_radix_digits_unit.sv =====
// Top level of the integer to radix digits unit: front intake, job queue and digit back end.
`timescale 1ns / 1ps
// Each item is first converted (decimal only), then its leading zero digit slots are
// skipped one per cycle (NDIG = (VALUE_BITS + 2) / 3 slots in all), then its characters
// are sent. The back end takes a new item only after the last character of the previous
// one has been sent; the two-entry queue holds two more.
// Reset is synchronous and active low; it sets the radix to decimal and empties the unit.

module integer_to_radix_digits_unit #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [6:0]            o_digit_char,
    output logic                  o_last_digit
);
    import irad_pkg::*;

    // Job handoff between the front and back parts. The front classifies the radix at
    // intake, so a configuration write never affects an item that is already queued.
    t_job_ctl              job;
    logic [VALUE_BITS-1:0] job_value;
    logic                  job_pop;

    // The front part holds the radix register and a short queue, so new items can be
    // taken while the back part is still sending the characters of an earlier item.
    irad_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_job        (job),
        .o_job_value  (job_value),
        .i_job_pop    (job_pop)
    );

    // The back part converts one item at a time. Decimal uses a shift-add-3 pass, one
    // input bit per cycle; octal and hex digits are taken straight from the value bits.
    // Leading zero digits are dropped, and the lowest digit is always sent, so a zero
    // value gives the single character '0'. Characters leave through an output register.
    irad_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_value (job_value),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_digit_char(o_digit_char),
        .o_last_digit(o_last_digit)
    );

endmodule

// ===== design/irad_front.sv =====
// Front part: radix register, item intake with radix classification, two-entry job queue.
`timescale 1ns / 1ps

module irad_front #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output irad_pkg::t_job_ctl    o_job,
    output logic [VALUE_BITS-1:0] o_job_value,
    input  logic                  i_job_pop
);
    import irad_pkg::*;

    localparam int QDEPTH = 2;

    logic [1:0]            r_radix_sel;
    logic [VALUE_BITS-1:0] r_q_value [QDEPTH];
    t_radix                r_q_radix [QDEPTH];
    logic                  r_wr_ptr, n_wr_ptr;
    logic                  r_rd_ptr, n_rd_ptr;
    logic [1:0]            r_count, n_count;
    logic                  push;
    logic                  pop;
    t_radix                radix_class;

    always_comb begin
        case (r_radix_sel)
            RADIX_SEL_OCT: radix_class = RADIX_OCT;
            RADIX_SEL_HEX: radix_class = RADIX_HEX;
            default:       radix_class = RADIX_DEC;
        endcase
    end

    assign o_stall     = (r_count == 2'(QDEPTH));
    assign push        = i_valid && !o_stall;
    assign pop         = i_job_pop && (r_count != 2'd0);
    assign o_job.valid = (r_count != 2'd0);
    assign o_job.radix = r_q_radix[r_rd_ptr];
    assign o_job_value = r_q_value[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_sel <= 2'd0;
            r_wr_ptr    <= 1'b0;
            r_rd_ptr    <= 1'b0;
            r_count     <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_radix_sel <= i_cfg_wr_data;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_value[r_wr_ptr] <= i_value;
            r_q_radix[r_wr_ptr] <= radix_class;
        end
    end

endmodule

// ===== design/irad_back.sv =====
// Back part: digit sequencer with shift-add-3 decimal conversion and an output register.
`timescale 1ns / 1ps

module irad_back #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  irad_pkg::t_job_ctl    i_job,
    input  logic [VALUE_BITS-1:0] i_job_value,
    output logic                  o_job_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [6:0]            o_digit_char,
    output logic                  o_last_digit
);
    import irad_pkg::*;

    // Digit slots: enough for octal, which also covers decimal and hexadecimal.
    localparam int NDIG = (VALUE_BITS + 2) / 3;
    localparam int DW   = 4 * NDIG;
    localparam int OW   = 3 * NDIG;
    localparam int CW   = $clog2(VALUE_BITS + 1);
    localparam int LW   = $clog2(NDIG + 1);

    t_state                r_state, n_state;
    logic [DW-1:0]         r_dig, n_dig;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [LW-1:0]         r_left, n_left;
    logic                  r_out_valid, n_out_valid;
    logic [6:0]            r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic                  out_free;
    logic [3:0]            top_digit;
    logic                  left_one;
    logic                  do_load;
    logic                  do_dabble;
    logic                  do_skip;
    logic                  do_emit;
    logic [DW-1:0]         dig_adj;
    logic [DW-1:0]         dig_oct;
    logic [DW-1:0]         dig_hex;
    logic [OW-1:0]         oct_pad;

    assign out_free  = !r_out_valid || !i_stall;
    assign top_digit = r_dig[DW-1 -: 4];
    assign left_one  = (r_left == LW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job.valid) begin
                    n_state = (i_job.radix == RADIX_DEC) ? ST_CONV : ST_SKIP;
                end
            end
            ST_CONV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit != 4'd0 || left_one) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && left_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        do_load   = 1'b0;
        do_dabble = 1'b0;
        do_skip   = 1'b0;
        do_emit   = 1'b0;
        case (r_state)
            ST_IDLE: do_load   = i_job.valid;
            ST_CONV: do_dabble = 1'b1;
            ST_SKIP: do_skip   = (top_digit == 4'd0) && !left_one;
            ST_EMIT: do_emit   = out_free;
            default: begin
            end
        endcase
    end

    assign o_job_pop = do_load;

    // Direct digit layouts for octal and hexadecimal.
    always_comb begin
        oct_pad = '0;
        oct_pad[VALUE_BITS-1:0] = i_job_value;
        dig_hex = '0;
        dig_hex[VALUE_BITS-1:0] = i_job_value;
        for (int i = 0; i < NDIG; i++) begin
            dig_oct[4*i +: 4] = {1'b0, oct_pad[3*i +: 3]};
        end
    end

    // One shift-add-3 correction per BCD digit.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_dig[4*i +: 4] >= BCD_ADJ_LIMIT) begin
                dig_adj[4*i +: 4] = r_dig[4*i +: 4] + BCD_ADJ_ADD;
            end else begin
                dig_adj[4*i +: 4] = r_dig[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_dig       = r_dig;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (do_load) begin
            n_left = LW'(NDIG);
            n_bin  = i_job_value;
            n_cnt  = CW'(VALUE_BITS);
            case (i_job.radix)
                RADIX_OCT: n_dig = dig_oct;
                RADIX_HEX: n_dig = dig_hex;
                default:   n_dig = '0;
            endcase
        end
        if (do_dabble) begin
            n_dig = {dig_adj[DW-2:0], r_bin[VALUE_BITS-1]};
            n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
        end
        if (do_skip || do_emit) begin
            n_dig  = {r_dig[DW-5:0], 4'd0};
            n_left = r_left - LW'(1);
        end
        if (do_emit) begin
            n_out_valid = 1'b1;
            n_out_char  = digit_to_ascii(top_digit);
            n_out_last  = left_one;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig      <= n_dig;
        r_bin      <= n_bin;
        r_cnt      <= n_cnt;
        r_left     <= n_left;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

endmodule

// ===== design/irad_checker.sv =====
// Port-level checks of the integer to radix digits unit, bound to its top level.
`timescale 1ns / 1ps

module irad_checker #(
    parameter int VALUE_BITS = 31
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_wr_en,
    input logic [1:0]            i_cfg_wr_data,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [VALUE_BITS-1:0] i_value,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [6:0]            o_digit_char,
    input logic                  o_last_digit
);
    import irad_pkg::*;

    // Set while a run of characters has started but its last one has not been taken.
    logic r_in_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (o_valid && !i_stall) begin
            r_in_run <= !o_last_digit;
        end
    end

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_char_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_char >= ASCII_ZERO && o_digit_char <= 7'h39) ||
                     (o_digit_char >= 7'h41 && o_digit_char <= 7'h46)))
        else $error("character is not a digit");

    a_no_leading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_in_run && o_digit_char == ASCII_ZERO) |-> o_last_digit)
        else $error("leading zero in a run");

    a_stalled_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_digit_char) && $stable(o_last_digit)))
        else $error("stalled output changed");

endmodule

bind integer_to_radix_digits_unit irad_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (.*);

// ===== dv/irad_digit_checker.sv =====
// Checker of the integer to radix digits unit: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module irad_digit_checker #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_wr_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [VALUE_BITS-1:0] i_in_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [6:0]            i_out_digit_char,
    input  logic                  i_out_last_digit,
    output int                    o_fail_count,
    output int                    o_pending
);
    import irad_pkg::*;

    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_digit_exp;

    t_digit_exp digit_queue[$];
    logic [1:0] radix_sel = 2'(RADIX_DEC);
    int         fail_count = 0;

    // Splits one value into characters, most significant first, and queues them.
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
                                           input logic [1:0] sel);
        logic [63:0] rest;
        logic [63:0] base;
        logic [3:0]  digs[64];
        int          n;
        int          k;
        t_digit_exp  e;
        case (sel)
            RADIX_SEL_OCT: base = 64'd8;
            RADIX_SEL_HEX: base = 64'd16;
            default:       base = 64'd10;
        endcase
        rest = 64'(v);
        n = 0;
        do begin
            digs[n] = 4'(rest % base);
            rest = rest / base;
            n++;
        end while (rest != 0);
        for (k = n - 1; k >= 0; k--) begin
            if (digs[k] < 4'd10) begin
                e.ch = CHAR_ZERO + 7'(digs[k]);
            end else begin
                e.ch = CHAR_UPPER_A + 7'(digs[k] - 4'd10);
            end
            e.last = (k == 0);
            digit_queue.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        t_digit_exp head;
        if (!i_rst_n) begin
            digit_queue.delete();
            radix_sel = 2'(RADIX_DEC);
        end else begin
            // Results first: a value accepted at this edge cannot produce a character yet.
            if (i_out_valid && !i_out_stall) begin
                if (digit_queue.size() == 0) begin
                    $error("unexpected digit item: digit_char %0d last_digit %0d",
                           i_out_digit_char, i_out_last_digit);
                    fail_count++;
                end else begin
                    head = digit_queue.pop_front();
                    if (i_out_digit_char !== head.ch) begin
                        $error("digit_char mismatch: expected %0d actual %0d",
                               head.ch, i_out_digit_char);
                        fail_count++;
                    end
                    if (i_out_last_digit !== head.last) begin
                        $error("last_digit mismatch: expected %0d actual %0d",
                               head.last, i_out_last_digit);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_digits(i_in_value, radix_sel);
            end
            if (i_cfg_wr_en) begin
                radix_sel = i_cfg_wr_data;
            end
        end
        o_pending    <= digit_queue.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top of the integer to radix digits unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import irad_pkg::*;

    localparam int VALUE_BITS      = 31;
    localparam int IDLE_LIMIT      = 4000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 31;
    localparam int SETTLE_CYCLES   = 80;

    // Radix codes the package does not name: decimal and the unused code.
    localparam logic [1:0] RADIX_SEL_DEC   = 2'd0;
    localparam logic [1:0] RADIX_SEL_SPARE = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } t_stall_mode;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_wr_data = 2'd0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [VALUE_BITS-1:0] in_value  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [6:0]            out_digit_char;
    logic                  out_last_digit;

    int fail_count;
    int pending_count;
    int burst_left = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_hold_left = 0;

    // Directed values: zero, all ones, and the powers of each radix with their neighbors.
    logic [VALUE_BITS-1:0] dec_vals[$] = '{31'd0, 31'h7FFFFFFF, 31'd999999999,
                                           31'd1000000000, 31'd9, 31'd10};
    logic [VALUE_BITS-1:0] oct_vals[$] = '{31'd0, 31'd7, 31'd8, 31'h3FFFFFFF,
                                           31'h40000000, 31'h7FFFFFFF};
    logic [VALUE_BITS-1:0] hex_vals[$] = '{31'd0, 31'd15, 31'd16, 31'h0FFFFFFF,
                                           31'h10000000, 31'h7FFFFFFF, 31'h2AAAAAAA};
    logic [VALUE_BITS-1:0] spare_vals[$] = '{31'd0, 31'h7FFFFFFF, 31'd10, 31'h55555555};

    always #5 clk = ~clk;

    integer_to_radix_digits_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_value      (in_value),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_digit_char (out_digit_char),
        .o_last_digit (out_last_digit)
    );

    irad_digit_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_value      (in_value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_digit_char(out_digit_char),
        .i_out_last_digit(out_last_digit),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    // The receiver switches between stall modes at random times, so that both
    // stretches without stalls and long back-pressure land on every part of a run.
    always @(negedge clk) begin
        if (stall_mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(16, 96);
        end
        stall_mode_left--;
        case (stall_mode)
            STALL_NONE: begin
                out_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                out_stall <= ($urandom_range(0, 99) < 30);
            end
            STALL_HEAVY: begin
                out_stall <= ($urandom_range(0, 99) < 70);
            end
            default: begin
                if (stall_hold_left > 0) begin
                    stall_hold_left--;
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                    if ($urandom_range(0, 15) == 0) begin
                        stall_hold_left = $urandom_range(4, 20);
                    end
                end
            end
        endcase
    end

    // Offers one value and returns at the edge where it is accepted. Values go out in
    // bursts of random length; between bursts valid may drop for a random gap.
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
            @(negedge clk);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end else begin
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_value <= v;
        burst_left--;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops the sender and waits until every queued character has come out.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0) @(negedge clk);
    endtask

    // The radix may change only while the unit holds no work.
    task automatic set_radix(input logic [1:0] sel);
        wait_idle();
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly values of random bit length, with full-width values, tiny values and
    // values next to a power of the radix mixed in.
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [63:0] raw;
        logic [63:0] base;
        logic [63:0] p;
        int          len;
        int          k;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1: begin
                return raw[VALUE_BITS-1:0];
            end
            2: begin
                return VALUE_BITS'($urandom_range(0, 20));
            end
            3: begin
                case ($urandom_range(0, 2))
                    0:       base = 64'd8;
                    1:       base = 64'd10;
                    default: base = 64'd16;
                endcase
                p = base;
                k = $urandom_range(0, 10);
                repeat (k) begin
                    if (p * base < (64'd1 << VALUE_BITS)) begin
                        p = p * base;
                    end
                end
                return VALUE_BITS'(p + 64'($urandom_range(0, 2)) - 64'd1);
            end
            default: begin
                len = $urandom_range(1, VALUE_BITS);
                return VALUE_BITS'(raw & ((64'd1 << len) - 64'd1));
            end
        endcase
    endfunction

    // Watchdog: counts clocks in which reset is released and neither channel accepts anything,
    // restarts the count on any acceptance, and ends the run as a failure when it reaches IDLE_LIMIT.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL integer_to_radix_digits_unit");
        $finish;
    end

    initial begin
        logic [1:0] sel;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: decimal straight out of reset, then every other radix code.
        foreach (dec_vals[i]) send_value(dec_vals[i]);
        set_radix(RADIX_SEL_OCT);
        foreach (oct_vals[i]) send_value(oct_vals[i]);
        set_radix(RADIX_SEL_HEX);
        foreach (hex_vals[i]) send_value(hex_vals[i]);
        set_radix(RADIX_SEL_SPARE);
        foreach (spare_vals[i]) send_value(spare_vals[i]);

        // Random part: each phase picks a radix code, the first one writes decimal.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            sel = (ph == 0) ? RADIX_SEL_DEC : 2'($urandom_range(0, 3));
            set_radix(sel);
            repeat (ITEMS_PER_PHASE) send_value(random_value());
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS integer_to_radix_digits_unit");
        end else begin
            $display("FAIL integer_to_radix_digits_unit");
        end
        $finish;
    end

endmodule
